@@ hw/rtl/aesenc_pkg.sv @@
// AES-256 encryption package: block types, S-box table and GF(2^8) helpers.
// Used by the key expander, the round logic and the top level.
package aesenc_pkg;

   localparam int NUM_ROUNDS = 14;
   localparam int KEY_WORDS  = 8;

   typedef logic [127:0] block_type;
   typedef logic [31:0]  word_type;

   typedef struct packed {
      logic busy;
      logic loading;
   } key_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] POLY_REDUCE = 8'h1b;
   localparam logic [7:0] RCON_FIRST  = 8'h01;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? POLY_REDUCE : 8'h00);
   endfunction

   function automatic word_type sub_word(input word_type w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

@@ hw/rtl/aesenc_round.sv @@
// One AES round, combinational: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aesenc_pkg. Byte i of the state sits at bits 127-8i down.
module aesenc_round #(
   parameter bit LAST = 1'b0
) (
   input  aesenc_pkg::block_type state_in,
   input  aesenc_pkg::block_type round_key,
   output aesenc_pkg::block_type state_out
);
   import aesenc_pkg::*;

   logic [7:0] sub_b [16];
   logic [7:0] shf_b [16];
   logic [7:0] mix_b [16];
   block_type  mixed;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sub_b[i] = SBOX[state_in[127 - 8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shf_b[r + 4*c] = sub_b[r + 4*((c + r) % 4)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         mix_b[4*c]   = xtime(shf_b[4*c]) ^ xtime(shf_b[4*c+1]) ^ shf_b[4*c+1]
                        ^ shf_b[4*c+2] ^ shf_b[4*c+3];
         mix_b[4*c+1] = shf_b[4*c] ^ xtime(shf_b[4*c+1]) ^ xtime(shf_b[4*c+2])
                        ^ shf_b[4*c+2] ^ shf_b[4*c+3];
         mix_b[4*c+2] = shf_b[4*c] ^ shf_b[4*c+1] ^ xtime(shf_b[4*c+2])
                        ^ xtime(shf_b[4*c+3]) ^ shf_b[4*c+3];
         mix_b[4*c+3] = xtime(shf_b[4*c]) ^ shf_b[4*c] ^ shf_b[4*c+1]
                        ^ shf_b[4*c+2] ^ xtime(shf_b[4*c+3]);
      end
      for (int i = 0; i < 16; i++) begin
         mixed[127 - 8*i -: 8] = LAST ? shf_b[i] : mix_b[i];
      end
   end

   assign state_out = mixed ^ round_key;

endmodule

@@ hw/rtl/aesenc_key_exp.sv @@
// AES-256 key registers and key expander, one schedule word per cycle.
// Depends on aesenc_pkg. Holds the full schedule in flip-flops.
module aesenc_key_exp #(
   parameter int NUM_ROUNDS = aesenc_pkg::NUM_ROUNDS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [1:0]                              csr_index,
   input  logic [63:0]                             csr_wdata,
   output aesenc_pkg::key_status_type              status,
   output logic [NUM_ROUNDS:0][127:0]              round_keys
);
   import aesenc_pkg::*;

   localparam int RK_DEPTH = 4 * (NUM_ROUNDS + 1);
   localparam int IDX_W    = $clog2(RK_DEPTH);
   localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(KEY_WORDS);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RK_DEPTH - 1);

   logic [63:0]      key_ff [4];
   word_type         rk_ff [RK_DEPTH];
   word_type         win_ff [KEY_WORDS];
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       rcon_ff, rcon_in;
   logic             start_ff, start_in;
   logic             busy_ff, busy_in;
   word_type         temp, new_word;

   always_comb begin
      temp = win_ff[KEY_WORDS-1];
      rcon_in = rcon_ff;
      unique case (idx_ff[2:0])
         3'd0: begin
            temp = sub_word({temp[23:0], temp[31:24]}) ^ {rcon_ff, 24'h0};
            rcon_in = xtime(rcon_ff);
         end
         3'd4: temp = sub_word(temp);
         default: temp = temp;
      endcase
      new_word = win_ff[0] ^ temp;
      start_in = csr_we;
      busy_in  = start_ff || (busy_ff && (idx_ff != IDX_LAST));
      idx_in   = start_ff ? IDX_FIRST : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         start_ff <= 1'b1;
         busy_ff  <= 1'b0;
      end else begin
         if (csr_we) key_ff[csr_index] <= csr_wdata;
         start_ff <= start_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_ff) begin
         for (int i = 0; i < 4; i++) begin
            rk_ff[2*i]      <= key_ff[i][63:32];
            rk_ff[2*i+1]    <= key_ff[i][31:0];
            win_ff[2*i]     <= key_ff[i][63:32];
            win_ff[2*i+1]   <= key_ff[i][31:0];
         end
         idx_ff  <= idx_in;
         rcon_ff <= RCON_FIRST;
      end else if (busy_ff) begin
         rk_ff[idx_ff] <= new_word;
         for (int i = 0; i < KEY_WORDS - 1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[KEY_WORDS-1] <= new_word;
         idx_ff  <= idx_in;
         rcon_ff <= rcon_in;
      end
   end

   always_comb begin
      for (int r = 0; r <= NUM_ROUNDS; r++) begin
         round_keys[r] = {rk_ff[4*r], rk_ff[4*r+1], rk_ff[4*r+2], rk_ff[4*r+3]};
      end
   end

   assign status.busy    = busy_ff;
   assign status.loading = start_ff;

   a_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start_ff && idx_ff == IDX_LAST |=> !busy_ff)
      else $error("key expander ran past last word");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> start_ff)
      else $error("key write did not restart expansion");
   a_run: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> busy_ff && idx_ff == IDX_FIRST)
      else $error("expansion did not start at first derived word");

endmodule

@@ hw/rtl/aes256_block_encrypt.sv @@
// AES-256 block encryption top level: key expander plus unrolled round pipeline.
// Depends on aesenc_pkg, aesenc_key_exp and aesenc_round.
//
//   channel | direction | handshake          | content
//   req     | in        | tvalid/tready      | plaintext word
//   rsp     | out       | tvalid/tready      | ciphertext word
//   csr     | in        | we, no wait        | key registers 0..3
//
// The pipeline has one initial key-add register and one register per round;
// one word enters per cycle while the key expander is idle and the pipeline is not stalled.
// After reset and after every key write the expander makes one load step and
// then one schedule word per cycle, with req_tready low throughout.
// Each stage holds on stall and takes a word as soon as its successor frees up.
module aes256_block_encrypt #(
   parameter int NUM_ROUNDS = aesenc_pkg::NUM_ROUNDS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // plain_high [63:0], plain_low [127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // cipher_high [63:0], cipher_low [127:64]
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import aesenc_pkg::*;

   key_status_type                 key_status;
   logic [NUM_ROUNDS:0][127:0]     round_keys;
   block_type                      st_ff [NUM_ROUNDS+1];
   logic [NUM_ROUNDS:0]            v_ff;
   logic [NUM_ROUNDS:0]            en;
   block_type                      rnd_out [NUM_ROUNDS+1];
   logic                           key_idle;

   aesenc_key_exp #(.NUM_ROUNDS(NUM_ROUNDS)) u_key (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .status(key_status), .round_keys
   );

   assign key_idle = !key_status.busy && !key_status.loading;

   always_comb begin
      en[NUM_ROUNDS] = !v_ff[NUM_ROUNDS] || rsp_tready;
      for (int k = NUM_ROUNDS - 1; k >= 0; k--) en[k] = !v_ff[k] || en[k+1];
   end

   assign req_tready = en[0] && key_idle;
   assign rnd_out[0] = {req_tdata[63:0], req_tdata[127:64]} ^ round_keys[0];

   for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
      aesenc_round #(.LAST(k == NUM_ROUNDS)) u_round (
         .state_in(st_ff[k-1]), .round_key(round_keys[k]), .state_out(rnd_out[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_tvalid && key_idle;
         for (int k = 1; k <= NUM_ROUNDS; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NUM_ROUNDS; k++) begin
         if (en[k]) st_ff[k] <= rnd_out[k];
      end
   end

   assign rsp_tvalid = v_ff[NUM_ROUNDS];
   assign rsp_tdata  = {st_ff[NUM_ROUNDS][63:0], st_ff[NUM_ROUNDS][127:64]};

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      key_status.busy |-> !req_tready)
      else $error("word taken during key expansion");
   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && !en[0] |=> v_ff[0] && $stable(st_ff[0]))
      else $error("first stage lost a stalled word");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && en[1] |=> v_ff[1])
      else $error("word dropped between first stages");

endmodule

@@ sim/tb.sv @@
// Self-checking bench for aes256_block_encrypt: computes AES-256 ciphertext
// per plaintext word and compares each result word. Depends on aesenc_pkg.
module tb;
   import aesenc_pkg::*;

   typedef enum logic [1:0] {KEY_REG_0 = 2'd0, KEY_REG_1 = 2'd1,
                             KEY_REG_2 = 2'd2, KEY_REG_3 = 2'd3} key_reg_type;

   localparam int PIPE_LATENCY = NUM_ROUNDS + 1;
   localparam int EXPAND_CYCLES = 60;
   localparam int EXP_DEPTH = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic [63:0] key_reg [4];
   logic [31:0] sched [60];
   logic [127:0] exp_mem [EXP_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int key_writes = 0;
   bit hold_rsp = 1'b0;
   int hold_cycles = 0;
   bit no_gaps = 1'b0;

   aes256_block_encrypt dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      gmul2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic void expand_schedule();
      logic [31:0] t;
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) begin
         sched[2*i] = key_reg[i][63:32];
         sched[2*i+1] = key_reg[i][31:0];
      end
      for (int i = 8; i < 60; i++) begin
         t = sched[i-1];
         if (i % 8 == 0) begin
            t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gmul2(rc);
         end else if (i % 8 == 4) begin
            t = sbox_word(t);
         end
         sched[i] = sched[i-8] ^ t;
      end
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [63:0] ph,
                                                  input logic [63:0] pl);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [63:0] ch, cl;
      for (int i = 0; i < 8; i++) begin
         s[i] = ph[56-8*i +: 8];
         s[8+i] = pl[56-8*i +: 8];
      end
      for (int r = 0; r <= NUM_ROUNDS; r++) begin
         if (r > 0) begin
            for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
            for (int c = 0; c < 4; c++)
               for (int w = 0; w < 4; w++) s[w+4*c] = t[w+4*((c+w)%4)];
            if (r < NUM_ROUNDS) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  s[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
                  s[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
                  s[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
                  s[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) s[4*c+w] ^= sched[4*r+c][24-8*w +: 8];
      end
      for (int i = 0; i < 8; i++) begin
         ch[56-8*i +: 8] = s[i];
         cl[56-8*i +: 8] = s[8+i];
      end
      encrypt_block = {cl, ch};
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (no_gaps) return 0;
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sender: one plaintext word
   task automatic send_block(input logic [63:0] ph, input logic [63:0] pl);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pl, ph};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_mem[exp_wr % EXP_DEPTH] = encrypt_block(ph, pl);
      exp_wr++;
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (PIPE_LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_key(input key_reg_type idx, input logic [63:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      key_reg[idx] = val;
      expand_schedule();
      key_writes++;
   endtask

   task automatic set_key(input logic [63:0] k0, k1, k2, k3);
      write_key(KEY_REG_0, k0);
      write_key(KEY_REG_1, k1);
      write_key(KEY_REG_2, k2);
      write_key(KEY_REG_3, k3);
   endtask

   function automatic logic [63:0] rand64();
      rand64 = {$urandom, $urandom};
   endfunction

   task automatic test_zero_key();
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
   endtask

   task automatic test_fips_vector();
      set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '1);
      send_block('1, '0);
      send_block(64'h8000000000000000, 64'h0000000000000001);
   endtask

   task automatic test_key_extremes();
      set_key('1, '1, '1, '1);
      send_block('0, '0);
      send_block('1, '1);
      set_key('0, '0, '0, '0);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
   endtask

   // key changed one register at a time, blocks between writes
   task automatic test_partial_key();
      for (int i = 0; i < 4; i++) begin
         write_key(key_reg_type'(i), rand64());
         send_block(rand64(), rand64());
         send_block(rand64(), rand64());
      end
   endtask

   task automatic test_random_blocks(input int n);
      for (int i = 0; i < n; i++) send_block(rand64(), rand64());
   endtask

   task automatic test_random_keys();
      for (int k = 0; k < 6; k++) begin
         set_key(rand64(), rand64(), rand64(), rand64());
         test_random_blocks(50);
      end
   endtask

   // receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      hold_cycles = 120;
      hold_rsp = 1'b1;
      no_gaps = 1'b1;
      test_random_blocks(40);
      no_gaps = 1'b0;
      drain();
      test_random_blocks(20);
   endtask

   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_wr == exp_rd) begin
            $error("unexpected result word %h", rsp_tdata);
            errors++;
         end else begin
            want = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_tdata[63:0] !== want[63:0]) begin
               $error("cipher_high expected %h actual %h", want[63:0], rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[127:64] !== want[127:64]) begin
               $error("cipher_low expected %h actual %h", want[127:64],
                      rsp_tdata[127:64]);
               errors++;
            end
            words_checked++;
         end
      end
   end

   initial begin
      int p;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_rsp = 1'b0;
         end
         p = $urandom_range(0, 99);
         if (p < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            if (p > 96) repeat ($urandom_range(8, 40)) @(negedge clock);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("** aes256_block_encrypt: FAILED **");
      $finish;
   end

   initial begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      expand_schedule();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      repeat (EXPAND_CYCLES) @(negedge clock);
      test_zero_key();
      test_fips_vector();
      test_key_extremes();
      test_partial_key();
      test_backpressure();
      test_random_keys();
      drain();
      $display("Covered %0d blocks, %0d checked, %0d key writes incl. partial keys.",
               words_sent, words_checked, key_writes);
      if (errors == 0 && exp_wr == exp_rd) begin
         $display("** aes256_block_encrypt: PASSED **");
      end else begin
         $display("** aes256_block_encrypt: FAILED **");
      end
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/aesenc_pkg.sv
hw/rtl/aesenc_round.sv
hw/rtl/aesenc_key_exp.sv
hw/rtl/aes256_block_encrypt.sv
sim/tb.sv
